// ----- sv/flash_region_config_check_assert.svh -----
// Assertion macros for the flash region configuration checker.
// Included by the top level; no other dependencies.
`ifndef FLASH_REGION_CONFIG_CHECK_ASSERT_SVH
`define FLASH_REGION_CONFIG_CHECK_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset
`define FRCC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("frcc assertion failed");
// Checked on every rising clock edge, reset included
`define FRCC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("frcc assertion failed");
`else
`define FRCC_ASSERT(label, prop)
`define FRCC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- sv/frcc_pkg.sv -----
// Shared constants for the flash region configuration checker.
// Status codes, item kinds, widths and parameter defaults; no dependencies.
`timescale 1ns / 1ps

package frcc_pkg;

   // Parameter defaults
   localparam int BANK_PAGES_DEF       = 256;
   localparam int BOOT_AREA_PAGES_DEF  = 32;
   localparam int REGIONS_PER_BANK_DEF = 3;
   localparam int MAX_REGIONS_DEF      = 6;
   localparam int HEADER_BYTES_DEF     = 8;
   localparam int ENTRY_BYTES_DEF      = 12;

   // Number of flash banks
   localparam int NUM_BANKS = 2;
   // Bits per byte of the stream buses
   localparam int BYTE_BITS = 8;

   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 3;
   localparam int FIELD_W  = 16;

   // Item kinds carried in tuser
   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_REGION = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_LENGTH   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BOOT_OVERLAP = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SLOT_FULL    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BOUNDS       = 3'd5;
   localparam logic [STATUS_W-1:0] ST_UNEXPECTED   = 3'd6;

endpackage

// ----- sv/flash_region_config_check.sv -----
// Flash region configuration record checker, top level.
// Uses frcc_pkg and the assertion macros in flash_region_config_check_assert.svh.
`timescale 1ns / 1ps

//  channel | direction | tdata (low bit up)                          | tuser    | tlast
//  req     | in        | record_length, region_start, region_pages   | opcode   | -
//  rsp     | out       | status, zero fill to 8 bits                 | -        | done_res
//
//  One result beat per request beat, one beat per cycle sustained while rsp_tready stays high;
//  each request beat passes through the input register, then the result register.
//  The header quotient multiply sits in front of the input register; the range checks
//  and the state update sit between the input register and the result register.
//  Synchronous active-high reset clears both valid flags and the record state.
//  A stalled result holds in the output register while one more request waits in
//  the input register; req_tready drops only when both are full and rsp_tready is low.

module flash_region_config_check #(
   parameter int BANK_PAGES       = frcc_pkg::BANK_PAGES_DEF,
   parameter int BOOT_AREA_PAGES  = frcc_pkg::BOOT_AREA_PAGES_DEF,
   parameter int REGIONS_PER_BANK = frcc_pkg::REGIONS_PER_BANK_DEF,
   parameter int MAX_REGIONS      = frcc_pkg::MAX_REGIONS_DEF,
   parameter int HEADER_BYTES     = frcc_pkg::HEADER_BYTES_DEF,
   parameter int ENTRY_BYTES      = frcc_pkg::ENTRY_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // record_length[15:0], region_start[31:16],
                                    // region_pages[47:32]
   input  logic [0:0]  req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // status[2:0], zero [7:3]
   output logic        rsp_tlast    // done_res
);

   localparam int SW = frcc_pkg::STATUS_W;
   localparam int CW = frcc_pkg::COUNT_W;
   localparam int FW = frcc_pkg::FIELD_W;
   localparam int AW = FW + 1;   // page address plus carry

   // Reciprocal of the entry size, exact for every 16-bit dividend
   localparam int RECIP_SHIFT = 23;
   localparam int PROD_W      = FW + RECIP_SHIFT;
   localparam logic [RECIP_SHIFT-1:0] RECIP =
      RECIP_SHIFT'(((1 << RECIP_SHIFT) + ENTRY_BYTES - 1) / ENTRY_BYTES);
   localparam int CHECK_W = FW + 7;

   // Page bounds
   localparam logic [AW-1:0] BOOT_A_END = AW'(BOOT_AREA_PAGES);
   localparam logic [AW-1:0] BANK_B_LO  = AW'(BANK_PAGES);
   localparam logic [AW-1:0] BOOT_B_END = AW'(BANK_PAGES + BOOT_AREA_PAGES);
   localparam logic [AW-1:0] FLASH_END  = AW'(frcc_pkg::NUM_BANKS * BANK_PAGES);

   // Input register
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_op_ff;
   logic [FW-1:0] s1_len_ff;
   logic [FW-1:0] s1_start_ff;
   logic [FW-1:0] s1_pages_ff;
   logic [FW-1:0] s1_quot_ff;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_status_ff, rsp_status_in;
   logic          rsp_done_ff, rsp_done_in;

   // Record state
   logic [CW-1:0] regions_left_ff, regions_left_in;
   logic [CW-1:0] bank_a_ff, bank_a_in;
   logic [CW-1:0] bank_b_ff, bank_b_in;
   logic [SW-1:0] sticky_ff, sticky_in;

   logic              accept;
   logic              advance;
   logic [FW-1:0]     req_rest;
   logic [PROD_W-1:0] req_prod;

   // Move the input register into the result register when it is free or drains
   assign advance    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign accept     = req_tvalid & req_tready;

   assign s1_valid_in  = accept | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_tready);

   // Quotient of the body length by the entry size, taken on the incoming beat
   assign req_rest = req_tdata[15:0] - FW'(HEADER_BYTES);
   assign req_prod = PROD_W'(req_rest) * PROD_W'(RECIP);

   // Header and region checks
   logic [FW-1:0]      rest;
   logic [CHECK_W-1:0] back_prod;
   logic [AW-1:0]      lo, hi;
   logic               boot_hit, in_bank_a, in_bank_b;

   assign rest      = s1_len_ff - FW'(HEADER_BYTES);
   assign back_prod = CHECK_W'(s1_quot_ff) * CHECK_W'(ENTRY_BYTES);
   assign lo        = AW'(s1_start_ff);
   assign hi        = AW'(s1_start_ff) + AW'(s1_pages_ff);

   assign boot_hit  = ((lo < BOOT_A_END) && (hi != '0)) ||
                      ((lo < BOOT_B_END) && (hi > BANK_B_LO));
   assign in_bank_a = (lo < BANK_B_LO) && (hi != '0) && (hi <= BANK_B_LO);
   assign in_bank_b = (lo >= BANK_B_LO) && (lo < FLASH_END) &&
                      (hi > BANK_B_LO) && (hi <= FLASH_END);

   always_comb begin
      logic [SW-1:0] code;
      regions_left_in = regions_left_ff;
      bank_a_in       = bank_a_ff;
      bank_b_in       = bank_b_ff;
      sticky_in       = sticky_ff;
      rsp_status_in   = frcc_pkg::ST_OK;
      rsp_done_in     = 1'b1;
      code            = frcc_pkg::ST_OK;
      if (s1_op_ff == frcc_pkg::OP_HEADER) begin
         // Start a new record, dropping any unfinished one
         regions_left_in = '0;
         bank_a_in       = '0;
         bank_b_in       = '0;
         sticky_in       = frcc_pkg::ST_OK;
         if (s1_len_ff < FW'(HEADER_BYTES) || back_prod != CHECK_W'(rest)) begin
            sticky_in     = frcc_pkg::ST_BAD_LENGTH;
            rsp_status_in = frcc_pkg::ST_BAD_LENGTH;
         end else if (s1_quot_ff > FW'(MAX_REGIONS)) begin
            sticky_in     = frcc_pkg::ST_TOO_MANY;
            rsp_status_in = frcc_pkg::ST_TOO_MANY;
         end else begin
            regions_left_in = s1_quot_ff[CW-1:0];
            rsp_done_in     = (s1_quot_ff[CW-1:0] == '0);
         end
      end else if (regions_left_ff == '0) begin
         // Region outside a record: report the first error of the record
         if (sticky_ff == frcc_pkg::ST_OK) begin
            sticky_in = frcc_pkg::ST_UNEXPECTED;
         end
         rsp_status_in = (sticky_ff == frcc_pkg::ST_OK) ? frcc_pkg::ST_UNEXPECTED
                                                          : sticky_ff;
      end else begin
         if (boot_hit) begin
            code = frcc_pkg::ST_BOOT_OVERLAP;
         end else if (in_bank_a) begin
            if (bank_a_ff >= CW'(REGIONS_PER_BANK)) begin
               code = frcc_pkg::ST_SLOT_FULL;
            end else begin
               bank_a_in = bank_a_ff + CW'(1);
            end
         end else if (in_bank_b) begin
            if (bank_b_ff >= CW'(REGIONS_PER_BANK)) begin
               code = frcc_pkg::ST_SLOT_FULL;
            end else begin
               bank_b_in = bank_b_ff + CW'(1);
            end
         end else begin
            code = frcc_pkg::ST_BOUNDS;
         end
         if (code != frcc_pkg::ST_OK) begin
            sticky_in       = code;
            regions_left_in = '0;
            rsp_status_in   = code;
         end else begin
            regions_left_in = regions_left_ff - CW'(1);
            rsp_done_in     = (regions_left_ff == CW'(1));
         end
      end
   end

   // Hold valid flags and record state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         regions_left_ff <= '0;
         bank_a_ff       <= '0;
         bank_b_ff       <= '0;
         sticky_ff       <= frcc_pkg::ST_OK;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            regions_left_ff <= regions_left_in;
            bank_a_ff       <= bank_a_in;
            bank_b_ff       <= bank_b_in;
            sticky_ff       <= sticky_in;
         end
      end
   end

   // Load the input beat and the result beat
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_tuser[0];
         s1_len_ff   <= req_tdata[15:0];
         s1_start_ff <= req_tdata[31:16];
         s1_pages_ff <= req_tdata[47:32];
         s1_quot_ff  <= req_prod[PROD_W-1:RECIP_SHIFT];
      end
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_done_ff   <= rsp_done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(frcc_pkg::BYTE_BITS - SW)'(0), rsp_status_ff};
   assign rsp_tlast  = rsp_done_ff;

   // Checks on the record state and the result beat
   logic [CW+1:0] placed_sum;
   assign placed_sum = (CW+2)'(bank_a_ff) + (CW+2)'(bank_b_ff) + (CW+2)'(regions_left_ff);

`include "flash_region_config_check_assert.svh"

   `FRCC_ASSERT(a_error_ends_record, (sticky_ff != frcc_pkg::ST_OK) |-> (regions_left_ff == '0))
   `FRCC_ASSERT(a_region_budget, placed_sum <= (CW+2)'(MAX_REGIONS))
   `FRCC_ASSERT(a_error_is_last, (rsp_valid_ff && rsp_status_ff != frcc_pkg::ST_OK) |-> rsp_done_ff)
   `FRCC_ASSERT(a_stage_holds, (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_len_ff)))
   `FRCC_ASSERT_ALWAYS(a_reset_clears, reset |=> (!rsp_valid_ff && !s1_valid_ff))

endmodule
